### design/lvw_pkg.sv
// Shared types and codes for the 3D voxel line walker.
// Used by lvw_span, lvw_walk and line_voxel_walker_3d; depends on nothing.
package lvw_pkg;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPAN,
        ST_PICK,
        ST_INIT,
        ST_WALK,
        ST_FLAG
    } t_state;

    // Axis index
    typedef logic [1:0] t_axis;

    localparam t_axis AX_X = 2'd0;
    localparam t_axis AX_Y = 2'd1;
    localparam t_axis AX_Z = 2'd2;

    // Result status codes
    localparam logic [1:0] STAT_POINT = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_LONG  = 2'd2;

    // Control from the sequencer to the walker
    typedef struct packed {
        logic load;
        logic adv;
    } t_walk_ctl;

endpackage

### design/line_voxel_walker_3d.sv
// Top level of the 3D voxel line walker: sequencer, input capture and
// output register. Depends on lvw_pkg, lvw_span and lvw_walk.
//
// Usage: one input beat on s_axis carries a start and an end voxel. The
// block answers on m_axis with every point strictly between them along
// the 3D Bresenham line, in walking order, m_axis_tlast on the final one.
// A line whose major span is 0 or 1 gives one beat with status empty; one
// with more than MAX_POINTS interior points gives one beat with status
// too long; both carry zero coordinates and tlast.
// Timing: after the input beat the span unit works through the axes on a
// shared subtractor, then the sequencer chooses the major axis and loads the
// walker. Points then leave at one per cycle while m_axis_tready does not
// stall them. s_axis_tready is high only while no item is in work; the next
// item can be taken while the final result still waits in the output
// register.
// A stall on m_axis_tready holds the walker in place; nothing is dropped.
// Reset (i_rst_n low at a clock edge) returns to idle and empties the
// output register.
module line_voxel_walker_3d #(
    parameter int COORD_BITS = 16,
    parameter int MAX_POINTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, zero fill
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // point_x, point_y, point_z, zero fill
    output logic [((3*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tlast
);
    import lvw_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int SW    = $clog2(MAX_POINTS + 2);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int ERR_W = SW + 3;
    localparam int OUT_W = ((3*COORD_BITS+7)/8)*8;

    t_state              r_state;
    t_state              n_state;
    logic [2:0][CW-1:0]  r_start;
    logic [2:0][CW-1:0]  r_end;
    t_axis               r_major;
    logic [1:0]          r_flag_status;

    logic                r_out_valid;
    logic [CW-1:0]       r_out_x;
    logic [CW-1:0]       r_out_y;
    logic [CW-1:0]       r_out_z;
    logic [1:0]          r_out_status;
    logic                r_out_last;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_load_pt;
    logic                w_load_flag;
    t_walk_ctl           w_ctl;

    logic [2:0][CW-1:0]  w_span;
    logic [2:0]          w_neg;
    logic                w_span_done;
    t_axis               w_major;
    logic [CW-1:0]       w_span_maj;
    logic                w_empty;
    logic                w_long;
    t_axis               w_m1;
    t_axis               w_m2;

    logic [CW-1:0]       w_next_maj;
    logic [CW-1:0]       w_next_m1;
    logic [CW-1:0]       w_next_m2;
    logic                w_last;
    logic [CW-1:0]       w_pt_x;
    logic [CW-1:0]       w_pt_y;
    logic [CW-1:0]       w_pt_z;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // Capture the endpoints of an accepted beat
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            for (int a = 0; a < 3; a++) begin
                r_start[a] <= s_axis_tdata[a*CW +: CW];
                r_end[a]   <= s_axis_tdata[(a+3)*CW +: CW];
            end
        end
    end

    lvw_span #(
        .CW (CW)
    ) u_span (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_start_pt (r_start),
        .i_end_pt   (r_end),
        .o_span     (w_span),
        .o_neg      (w_neg),
        .o_done     (w_span_done)
    );

    // Pick the major axis; ties go to x, then y
    always_comb begin
        priority if (w_span[AX_X] >= w_span[AX_Y] && w_span[AX_X] >= w_span[AX_Z]) begin
            w_major = AX_X;
        end else if (w_span[AX_Y] >= w_span[AX_Z]) begin
            w_major = AX_Y;
        end else begin
            w_major = AX_Z;
        end
        w_span_maj = w_span[w_major];
        w_empty    = 32'(w_span_maj) <= 32'd1;
        w_long     = 32'(w_span_maj) > 32'(MAX_POINTS + 1);
    end

    assign w_m1 = (r_major == AX_X) ? AX_Y : AX_X;
    assign w_m2 = (r_major == AX_Z) ? AX_Y : AX_Z;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PICK) begin
            r_major       <= w_major;
            r_flag_status <= w_empty ? STAT_EMPTY : STAT_LONG;
        end
    end

    lvw_walk #(
        .CW    (CW),
        .SW    (SW),
        .CNT_W (CNT_W),
        .ERR_W (ERR_W)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_pos_maj  (r_start[r_major]),
        .i_pos_m1   (r_start[w_m1]),
        .i_pos_m2   (r_start[w_m2]),
        .i_neg      ({w_neg[w_m2], w_neg[w_m1], w_neg[r_major]}),
        .i_span_maj (SW'(w_span[r_major])),
        .i_span_m1  (SW'(w_span[w_m1])),
        .i_span_m2  (SW'(w_span[w_m2])),
        .o_next_maj (w_next_maj),
        .o_next_m1  (w_next_m1),
        .o_next_m2  (w_next_m2),
        .o_last     (w_last)
    );

    // Map walker axes back to x, y, z
    always_comb begin
        unique case (r_major)
            AX_X: begin
                w_pt_x = w_next_maj;
                w_pt_y = w_next_m1;
                w_pt_z = w_next_m2;
            end
            AX_Y: begin
                w_pt_x = w_next_m1;
                w_pt_y = w_next_maj;
                w_pt_z = w_next_m2;
            end
            AX_Z: begin
                w_pt_x = w_next_m1;
                w_pt_y = w_next_m2;
                w_pt_z = w_next_maj;
            end
            default: begin
                w_pt_x = w_next_maj;
                w_pt_y = w_next_m1;
                w_pt_z = w_next_m2;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_acc) n_state = ST_SPAN;
            ST_SPAN: if (w_span_done) n_state = ST_PICK;
            ST_PICK: n_state = (w_empty || w_long) ? ST_FLAG : ST_INIT;
            ST_INIT: n_state = ST_WALK;
            ST_WALK: if (w_out_free && w_last) n_state = ST_IDLE;
            ST_FLAG: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_ctl         = '0;
        w_load_pt     = 1'b0;
        w_load_flag   = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_INIT: w_ctl.load = 1'b1;
            ST_WALK: begin
                w_ctl.adv = w_out_free;
                w_load_pt = w_out_free;
            end
            ST_FLAG: w_load_flag = w_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register: fill on a point or a flag, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_pt || w_load_flag) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_pt) begin
            r_out_x      <= w_pt_x;
            r_out_y      <= w_pt_y;
            r_out_z      <= w_pt_z;
            r_out_status <= STAT_POINT;
            r_out_last   <= w_last;
        end else if (w_load_flag) begin
            r_out_x      <= '0;
            r_out_y      <= '0;
            r_out_z      <= '0;
            r_out_status <= r_flag_status;
            r_out_last   <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_out_z, r_out_y, r_out_x});
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

### design/lvw_span.sv
// Span unit: one shared subtractor computes |end - start| and the step
// direction of each axis, one axis after another. Depends on lvw_pkg.
module lvw_span #(
    parameter int CW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [2:0][CW-1:0]   i_start_pt,
    input  logic [2:0][CW-1:0]   i_end_pt,
    output logic [2:0][CW-1:0]   o_span,
    output logic [2:0]           o_neg,
    output logic                 o_done
);
    import lvw_pkg::*;

    logic                 r_busy;
    logic                 r_abs;
    t_axis                r_axis;
    logic signed [CW:0]   r_diff;
    logic [2:0][CW-1:0]   r_span;
    logic [2:0]           r_neg;

    logic signed [CW:0]   w_opa;
    logic signed [CW:0]   w_opb;
    logic signed [CW:0]   w_res;

    // Select operands: difference first, then negate when it came out negative
    always_comb begin
        if (r_abs) begin
            w_opa = '0;
            w_opb = r_diff;
        end else begin
            w_opa = $signed({i_end_pt[r_axis][CW-1], i_end_pt[r_axis]});
            w_opb = $signed({i_start_pt[r_axis][CW-1], i_start_pt[r_axis]});
        end
        w_res = w_opa - w_opb;
    end

    // Sequence the two phases over the three axes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_abs  <= 1'b0;
            r_axis <= AX_X;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_abs  <= 1'b0;
            r_axis <= AX_X;
        end else if (r_busy) begin
            r_abs <= !r_abs;
            if (r_abs) begin
                if (r_axis == AX_Z) begin
                    r_busy <= 1'b0;
                end else begin
                    r_axis <= r_axis + 2'd1;
                end
            end
        end
    end

    // Hold difference, magnitude and direction
    always_ff @(posedge i_clk) begin
        if (r_busy && !r_abs) begin
            r_diff <= w_res;
        end
        if (r_busy && r_abs) begin
            r_span[r_axis] <= r_diff[CW] ? w_res[CW-1:0] : r_diff[CW-1:0];
            r_neg[r_axis]  <= r_diff[CW];
        end
    end

    assign o_span = r_span;
    assign o_neg  = r_neg;
    assign o_done = r_busy && r_abs && (r_axis == AX_Z);

endmodule

### design/lvw_walk.sv
// Walker: steps the major axis once per advance and the two minor axes
// under their own error terms; gives the next interior point. Depends on lvw_pkg.
module lvw_walk #(
    parameter int CW    = 16,
    parameter int SW    = 7,
    parameter int CNT_W = 7,
    parameter int ERR_W = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lvw_pkg::t_walk_ctl  i_ctl,
    input  logic [CW-1:0]       i_pos_maj,
    input  logic [CW-1:0]       i_pos_m1,
    input  logic [CW-1:0]       i_pos_m2,
    input  logic [2:0]          i_neg,      // bit 0 major, bit 1 minor 1, bit 2 minor 2
    input  logic [SW-1:0]       i_span_maj,
    input  logic [SW-1:0]       i_span_m1,
    input  logic [SW-1:0]       i_span_m2,
    output logic [CW-1:0]       o_next_maj,
    output logic [CW-1:0]       o_next_m1,
    output logic [CW-1:0]       o_next_m2,
    output logic                o_last
);
    import lvw_pkg::*;

    logic [CW-1:0]            r_pos_maj;
    logic [CW-1:0]            r_pos_m1;
    logic [CW-1:0]            r_pos_m2;
    logic [2:0]               r_neg;
    logic signed [ERR_W-1:0]  r_two_maj;
    logic signed [ERR_W-1:0]  r_two_m1;
    logic signed [ERR_W-1:0]  r_two_m2;
    logic signed [ERR_W-1:0]  r_e1;
    logic signed [ERR_W-1:0]  r_e2;
    logic [CNT_W-1:0]         r_cnt;

    logic signed [ERR_W-1:0]  w_two_maj;
    logic signed [ERR_W-1:0]  w_two_m1;
    logic signed [ERR_W-1:0]  w_two_m2;
    logic                     w_hit1;
    logic                     w_hit2;
    logic signed [ERR_W-1:0]  n_e1;
    logic signed [ERR_W-1:0]  n_e2;

    // Doubled spans for the error terms
    assign w_two_maj = $signed(ERR_W'({i_span_maj, 1'b0}));
    assign w_two_m1  = $signed(ERR_W'({i_span_m1, 1'b0}));
    assign w_two_m2  = $signed(ERR_W'({i_span_m2, 1'b0}));

    // Step a minor axis when its error term is above zero
    assign w_hit1 = !r_e1[ERR_W-1] && (r_e1 != '0);
    assign w_hit2 = !r_e2[ERR_W-1] && (r_e2 != '0);

    always_comb begin
        n_e1 = r_e1 - (w_hit1 ? r_two_maj : '0) + r_two_m1;
        n_e2 = r_e2 - (w_hit2 ? r_two_maj : '0) + r_two_m2;
        o_next_maj = r_pos_maj + (r_neg[0] ? {CW{1'b1}} : CW'(1));
        o_next_m1  = w_hit1 ? r_pos_m1 + (r_neg[1] ? {CW{1'b1}} : CW'(1)) : r_pos_m1;
        o_next_m2  = w_hit2 ? r_pos_m2 + (r_neg[2] ? {CW{1'b1}} : CW'(1)) : r_pos_m2;
    end

    assign o_last = (r_cnt == CNT_W'(1));

    // Count the points still to come
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= CNT_W'(i_span_maj - SW'(1));
        end else if (i_ctl.adv) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Load the start point, then advance one point per beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_pos_maj <= i_pos_maj;
            r_pos_m1  <= i_pos_m1;
            r_pos_m2  <= i_pos_m2;
            r_neg     <= i_neg;
            r_two_maj <= w_two_maj;
            r_two_m1  <= w_two_m1;
            r_two_m2  <= w_two_m2;
            r_e1      <= w_two_m1 - $signed(ERR_W'(i_span_maj));
            r_e2      <= w_two_m2 - $signed(ERR_W'(i_span_maj));
        end else if (i_ctl.adv) begin
            r_pos_maj <= o_next_maj;
            r_pos_m1  <= o_next_m1;
            r_pos_m2  <= o_next_m2;
            r_e1      <= n_e1;
            r_e2      <= n_e2;
        end
    end

endmodule
